>>> src/aabb_broadphase_overlap_table_defines.svh
// assertion macros shared by the broadphase table rtl
`ifndef AABB_BROADPHASE_OVERLAP_TABLE_DEFINES_SVH
`define AABB_BROADPHASE_OVERLAP_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// check a property while out of reset
`define ABO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property at every edge, reset included
`define ABO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ABO_ASSERT(lbl, prop, msg)
`define ABO_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> src/abo_pkg.sv
// shared constants and codes for the broadphase overlap table
package abo_pkg;

  // default sizes
  localparam int SLOT_COUNT_DEF = 64;
  localparam int COORD_BITS_DEF = 32;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // entry layout: used flag, world-only flag, then the six coordinates
  localparam int F_USED = 0;
  localparam int F_WO   = 1;
  localparam int F_BOX  = 2;

endpackage

>>> src/abo_cell.sv
// one ring cell holding a single slot entry
module abo_cell #(
  parameter int ENTRY_W = 2 + 6 * abo_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift,
  input  logic [ENTRY_W-1:0] d,
  output logic [ENTRY_W-1:0] q
);

  logic               used_r;
  logic [ENTRY_W-2:0] rest_r;

  // used flag clears on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (shift) begin
      used_r <= d[abo_pkg::F_USED];
    end
  end

  // payload moves with the ring
  always_ff @(posedge clk) begin
    if (shift) begin
      rest_r <= d[ENTRY_W-1:1];
    end
  end

  assign q = {rest_r, used_r};

endmodule

>>> src/abo_olap.sv
// signed box overlap test, touching counts as overlap
module abo_olap #(
  parameter int COORD_BITS = abo_pkg::COORD_BITS_DEF
) (
  input  logic [6*COORD_BITS-1:0] box_a,
  input  logic [6*COORD_BITS-1:0] box_b,
  output logic                    overlap
);

  logic signed [COORD_BITS-1:0] alo [3];
  logic signed [COORD_BITS-1:0] ahi [3];
  logic signed [COORD_BITS-1:0] blo [3];
  logic signed [COORD_BITS-1:0] bhi [3];
  logic [2:0]                   apart;

  // per axis: apart if one upper bound lies strictly below the other lower
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      alo[a]   = box_a[a*COORD_BITS +: COORD_BITS];
      ahi[a]   = box_a[(a+3)*COORD_BITS +: COORD_BITS];
      blo[a]   = box_b[a*COORD_BITS +: COORD_BITS];
      bhi[a]   = box_b[(a+3)*COORD_BITS +: COORD_BITS];
      apart[a] = (bhi[a] < alo[a]) || (ahi[a] < blo[a]);
    end
    overlap = ~|apart;
  end

endmodule

>>> src/aabb_broadphase_overlap_table.sv
// broadphase box table: rotating ring of slot cells with overlap query
//
//  channel  | handshake          | fields
//  ---------+--------------------+-------------------------------------------
//  input    | start / busy       | in_command, in_slot, in_min_*, in_max_*,
//           |                    | in_world_only
//  result   | out_strobe         | out_status, out_result_slot, out_has_slot,
//           |                    | out_last
//
// the slot entries sit in a ring of SLOT_COUNT cells rotating one slot per cycle
// during a scan, past a single head position. insert, remove and update take one
// full turn plus a done step; a query takes one turn to fetch the target box and,
// if found and not world-only, a second turn to compare it against each other slot.
// each result shows for one cycle on out_strobe; the receiver cannot stall.
// reset clears all used flags at once; no clearing pass is needed.
`include "aabb_broadphase_overlap_table_defines.svh"
module aabb_broadphase_overlap_table #(
  parameter int SLOT_COUNT = abo_pkg::SLOT_COUNT_DEF,
  parameter int COORD_BITS = abo_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [5:0]  in_slot,
  input  logic [31:0] in_min_x,
  input  logic [31:0] in_min_y,
  input  logic [31:0] in_min_z,
  input  logic [31:0] in_max_x,
  input  logic [31:0] in_max_y,
  input  logic [31:0] in_max_z,
  input  logic        in_world_only,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [5:0]  out_result_slot,
  output logic        out_has_slot,
  output logic        out_last
);

  localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CMP_W   = (IDX_W > 6) ? IDX_W : 6;
  localparam int BOX_W   = 6 * COORD_BITS;
  localparam int ENTRY_W = abo_pkg::F_BOX + BOX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DONE,
    S_QSCAN,
    S_QDONE
  } state_t;

  // sign-extend a 32-bit input and keep COORD_BITS of it
  function automatic logic [COORD_BITS-1:0] to_coord(input logic [31:0] v);
    logic [63:0] ext;
    ext = {{32{v[31]}}, v};
    return ext[COORD_BITS-1:0];
  endfunction

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [1:0]         cmd_r;
  logic [5:0]         slot_r;
  logic [ENTRY_W-1:0] new_ent_r;
  logic [BOX_W-1:0]   tgt_box_r;
  logic               tgt_wo_r, tgt_wo_nxt;
  logic               found_r, found_nxt;
  logic [5:0]         hit_slot_r, hit_slot_nxt;
  logic               pend_r, pend_nxt;
  logic [5:0]         pend_slot_r, pend_slot_nxt;
  logic               strobe_nxt;
  logic [1:0]         status_nxt;
  logic [5:0]         rslot_nxt;
  logic               has_nxt, last_nxt;
  logic [1:0]         out_status_r;
  logic [5:0]         out_result_slot_r;
  logic               out_strobe_r, out_has_slot_r, out_last_r;

  logic [ENTRY_W-1:0] cell_q [SLOT_COUNT];
  logic [ENTRY_W-1:0] head, ring_in;
  logic               shift, at_slot, at_end, olap, cap_tgt, accept;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign head    = cell_q[0];
  assign shift   = (state_r == S_SCAN) || (state_r == S_QSCAN);
  assign at_slot = (CMP_W'(pos_r) == CMP_W'(slot_r));
  assign at_end  = (pos_r == IDX_W'(SLOT_COUNT - 1));

  // ring of slot cells, head at cell 0, tail fed with the head's new value
  for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_ring
    logic [ENTRY_W-1:0] d_k;
    if (k == SLOT_COUNT - 1) begin : g_tail
      assign d_k = ring_in;
    end else begin : g_mid
      assign d_k = cell_q[k+1];
    end
    abo_cell #(.ENTRY_W(ENTRY_W)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (shift),
      .d     (d_k),
      .q     (cell_q[k])
    );
  end

  // overlap of the head slot against the query target
  abo_olap #(.COORD_BITS(COORD_BITS)) u_olap (
    .box_a   (tgt_box_r),
    .box_b   (head[abo_pkg::F_BOX +: BOX_W]),
    .overlap (olap)
  );

  // head update and sequencing
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    found_nxt     = found_r;
    hit_slot_nxt  = hit_slot_r;
    pend_nxt      = pend_r;
    pend_slot_nxt = pend_slot_r;
    tgt_wo_nxt    = tgt_wo_r;
    ring_in       = head;
    cap_tgt       = 1'b0;
    strobe_nxt    = 1'b0;
    status_nxt    = abo_pkg::ST_OK;
    rslot_nxt     = '0;
    has_nxt       = 1'b0;
    last_nxt      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
          pos_nxt   = '0;
          found_nxt = 1'b0;
          pend_nxt  = 1'b0;
        end
      end
      S_SCAN: begin
        case (cmd_r)
          abo_pkg::CMD_INSERT: begin
            if (!found_r && !head[abo_pkg::F_USED]) begin
              ring_in      = new_ent_r;
              found_nxt    = 1'b1;
              hit_slot_nxt = 6'(pos_r);
            end
          end
          abo_pkg::CMD_REMOVE: begin
            if (at_slot && head[abo_pkg::F_USED]) begin
              ring_in[abo_pkg::F_USED] = 1'b0;
              found_nxt                = 1'b1;
            end
          end
          abo_pkg::CMD_UPDATE: begin
            if (at_slot && head[abo_pkg::F_USED]) begin
              ring_in   = new_ent_r;
              found_nxt = 1'b1;
            end
          end
          default: begin
            if (at_slot && head[abo_pkg::F_USED]) begin
              cap_tgt    = 1'b1;
              tgt_wo_nxt = head[abo_pkg::F_WO];
              found_nxt  = 1'b1;
            end
          end
        endcase
        pos_nxt = pos_r + 1'b1;
        if (at_end) begin
          pos_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        last_nxt   = 1'b1;
        case (cmd_r)
          abo_pkg::CMD_INSERT: begin
            status_nxt = found_r ? abo_pkg::ST_OK : abo_pkg::ST_FULL;
            has_nxt    = found_r;
            rslot_nxt  = found_r ? hit_slot_r : 6'd0;
          end
          abo_pkg::CMD_QUERY: begin
            status_nxt = found_r ? abo_pkg::ST_OK : abo_pkg::ST_INVALID;
            if (found_r && !tgt_wo_r) begin
              strobe_nxt = 1'b0;
              last_nxt   = 1'b0;
              state_nxt  = S_QSCAN;
            end
          end
          default: begin
            status_nxt = found_r ? abo_pkg::ST_OK : abo_pkg::ST_INVALID;
          end
        endcase
      end
      S_QSCAN: begin
        if (!at_slot && head[abo_pkg::F_USED] && !head[abo_pkg::F_WO] && olap) begin
          // a new hit releases the one held back
          if (pend_r) begin
            strobe_nxt = 1'b1;
            has_nxt    = 1'b1;
            rslot_nxt  = pend_slot_r;
          end
          pend_nxt      = 1'b1;
          pend_slot_nxt = 6'(pos_r);
        end
        pos_nxt = pos_r + 1'b1;
        if (at_end) begin
          pos_nxt   = '0;
          state_nxt = S_QDONE;
        end
      end
      S_QDONE: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        last_nxt   = 1'b1;
        has_nxt    = pend_r;
        rslot_nxt  = pend_r ? pend_slot_r : 6'd0;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      pos_r             <= '0;
      found_r           <= 1'b0;
      hit_slot_r        <= '0;
      pend_r            <= 1'b0;
      pend_slot_r       <= '0;
      tgt_wo_r          <= 1'b0;
      out_strobe_r      <= 1'b0;
      out_status_r      <= abo_pkg::ST_OK;
      out_result_slot_r <= '0;
      out_has_slot_r    <= 1'b0;
      out_last_r        <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      pos_r             <= pos_nxt;
      found_r           <= found_nxt;
      hit_slot_r        <= hit_slot_nxt;
      pend_r            <= pend_nxt;
      pend_slot_r       <= pend_slot_nxt;
      tgt_wo_r          <= tgt_wo_nxt;
      out_strobe_r      <= strobe_nxt;
      out_status_r      <= status_nxt;
      out_result_slot_r <= rslot_nxt;
      out_has_slot_r    <= has_nxt;
      out_last_r        <= last_nxt;
    end
  end

  // transaction payload and query target capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_command;
      slot_r    <= in_slot;
      new_ent_r <= {to_coord(in_max_z), to_coord(in_max_y), to_coord(in_max_x),
                    to_coord(in_min_z), to_coord(in_min_y), to_coord(in_min_x),
                    in_world_only, 1'b1};
    end
    if (cap_tgt) begin
      tgt_box_r <= head[abo_pkg::F_BOX +: BOX_W];
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_result_slot = out_result_slot_r;
  assign out_has_slot    = out_has_slot_r;
  assign out_last        = out_last_r;

  // checks
  `ABO_ASSERT(a_has_only_ok, !(out_strobe && out_has_slot && out_status != abo_pkg::ST_OK), "slot given with error status")
  `ABO_ASSERT(a_notlast_in_query, (out_strobe && !out_last) |-> (state_r == S_QSCAN || state_r == S_QDONE), "non-final result outside query scan")
  `ABO_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction did not raise busy")
  `ABO_ASSERT_ALWAYS(a_ring_aligned, (pos_r != '0) |-> (state_r == S_SCAN || state_r == S_QSCAN), "ring left unaligned")

endmodule
